[rtl/abl_pkg.sv]
// shared types and constants for the audio bar level meter
package abl_pkg;

	typedef struct packed {
		logic [11:0] sample;
		logic        frame_end;
	} smp_t;

	typedef struct packed {
		logic       frame_kind;
		logic [3:0] bars_lit;
		logic [8:0] hue;
		logic [3:0] target_bars;
		logic       last;
	} res_t;

	// one frame level travelling from front to back
	typedef struct packed {
		logic        vld;
		logic [11:0] level;
	} lvl_word_t;

	typedef struct packed {
		logic        start;
		logic [15:0] dividend;
		logic [11:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] quot;
		logic [11:0] rem;
	} div_rsp_t;

	localparam logic CFG_SENS  = 1'b0;
	localparam logic CFG_QUIET = 1'b1;

	localparam logic KIND_BLANK = 1'b0;
	localparam logic KIND_STEP  = 1'b1;

	localparam logic [11:0] SENS_RESET  = 12'd200;
	localparam logic [11:0] QUIET_RESET = 12'd240;
	localparam logic [11:0] AVG_RESET   = 12'd20;
	localparam logic [8:0]  HUE_STEP    = 9'd60;
	localparam logic [8:0]  HUE_WRAP    = 9'd360;

	localparam int DIV_STEPS = 16;
	localparam int DIV_CW    = $clog2(DIV_STEPS);

	localparam int LQ_DEPTH = 2;
	localparam int LQ_AW    = $clog2(LQ_DEPTH);
	localparam int LQ_CW    = $clog2(LQ_DEPTH + 1);

endpackage

[rtl/abl_front.sv]
// front end: frame peak tracking and level extraction
module abl_front import abl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        smp_valid,
	output logic        smp_stall,
	input  smp_t        smp,
	input  logic [11:0] quiet_level,
	input  logic        lq_full,
	output lvl_word_t   push
);

	logic [11:0] peak_q;
	logic [11:0] peak_nx;
	logic        acc;

	assign smp_stall = lq_full;
	assign acc       = smp_valid && !smp_stall;
	assign peak_nx   = (smp.sample > peak_q) ? smp.sample : peak_q;

	always_comb begin
		push.vld   = acc && smp.frame_end;
		push.level = (peak_nx >= quiet_level) ? (peak_nx - quiet_level)
		                                      : (quiet_level - peak_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
		end else if (acc) begin
			peak_q <= smp.frame_end ? 12'd0 : peak_nx;
		end
	end

endmodule

[rtl/abl_fifo.sv]
// short level queue between front and back
module abl_fifo import abl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  lvl_word_t push,
	output logic      full,
	input  logic      pop,
	output lvl_word_t head
);

	logic [11:0]      mem_q [LQ_DEPTH];
	logic [LQ_AW-1:0] wr_ptr_q;
	logic [LQ_AW-1:0] rd_ptr_q;
	logic [LQ_CW-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == LQ_CW'(LQ_DEPTH));
	assign head.vld   = (count_q != '0);
	assign head.level = mem_q[rd_ptr_q];
	assign do_push    = push.vld && !full;
	assign do_pop     = pop && head.vld;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LQ_AW'(LQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LQ_AW'(LQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/abl_div.sv]
// restoring divider, one quotient bit per cycle
module abl_div import abl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [15:0]       dvd_q;
	logic [11:0]       dsr_q;
	logic [11:0]       rem_q;
	logic [12:0]       trial;
	logic              ge;
	logic [12:0]       rem_nx;

	assign trial  = {rem_q, dvd_q[15]};
	assign ge     = trial >= {1'b0, dsr_q};
	assign rem_nx = ge ? (trial - {1'b0, dsr_q}) : trial;

	assign rsp.done = done_q;
	assign rsp.quot = dvd_q;
	assign rsp.rem  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CW'(DIV_STEPS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// quotient bits shift in where the dividend shifts out
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[14:0], ge};
			rem_q <= rem_nx[11:0];
		end
	end

endmodule

[rtl/abl_back.sv]
// back end: block average, target bars, hue and animation steps
module abl_back import abl_pkg::*; #(
	parameter int BLOCK_FRAMES = 10,
	parameter int MAX_BARS     = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [11:0] sensitivity,
	input  lvl_word_t   head,
	output logic        pop,
	output div_req_t    div_req,
	input  div_rsp_t    div_rsp,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res
);

	localparam logic [4:0] BF = 5'(BLOCK_FRAMES);
	localparam logic [3:0] MB = 4'(MAX_BARS);

	// floor(x / BLOCK_FRAMES) == (x * AVG_RECIP) >> AVG_SH for every 16-bit x
	localparam int          AVG_SH    = 16 + $clog2(BLOCK_FRAMES);
	localparam logic [16:0] AVG_RECIP =
		17'(((1 << AVG_SH) + BLOCK_FRAMES - 1) / BLOCK_FRAMES);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AVG,
		ST_TGT,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t      state_q;
	logic [11:0] level_q;
	logic [15:0] sum_q;
	logic [15:0] blk_sum_q;
	logic [3:0]  cnt_q;
	logic [11:0] avg_q;
	logic [3:0]  shown_q;
	logic [3:0]  bars_q;
	logic [3:0]  target_q;
	logic [8:0]  hue_q;
	logic        blank_q;
	logic        below_q;
	div_req_t    div_req_q;
	logic        res_valid_q;
	res_t        res_q;

	logic [15:0] sum_nx;
	logic [4:0]  cnt_nx;
	logic [8:0]  hue_nx;
	logic        ld;
	logic [16:0] up_t;
	logic [16:0] c_up;
	logic [3:0]  tgt_div;
	logic [32:0] avg_prod;

	assign pop       = (state_q == ST_IDLE) && head.vld;
	assign div_req   = div_req_q;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign sum_nx   = sum_q + {4'd0, head.level};
	assign cnt_nx   = {1'b0, cnt_q} + 5'd1;
	assign hue_nx   = (hue_q + HUE_STEP >= HUE_WRAP) ? 9'd0 : hue_q + HUE_STEP;
	assign ld       = !res_valid_q || !res_stall;
	assign avg_prod = {17'd0, blk_sum_q} * {16'd0, AVG_RECIP};

	// target from the quotient: seven minus its ceiling below the average, floor plus eight above, capped at MAX_BARS
	always_comb begin
		c_up = {1'b0, div_rsp.quot} + {16'd0, (div_rsp.rem != '0)};
		if (below_q) begin
			up_t = (c_up >= 17'd7) ? 17'd0 : 17'd7 - c_up;
		end else begin
			up_t = {1'b0, div_rsp.quot} + 17'd8;
		end
		tgt_div = (up_t > {13'd0, MB}) ? MB : up_t[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			blk_sum_q   <= '0;
			cnt_q       <= '0;
			avg_q       <= AVG_RESET;
			shown_q     <= '0;
			hue_q       <= '0;
			blank_q     <= 1'b0;
			below_q     <= 1'b0;
			div_req_q   <= '0;
			res_valid_q <= 1'b0;
			level_q     <= '0;
			bars_q      <= '0;
			target_q    <= '0;
			res_q       <= '0;
		end else begin
			div_req_q.start <= 1'b0;
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (head.vld) begin
						level_q <= head.level;
						bars_q  <= shown_q;
						hue_q   <= hue_nx;
						if (cnt_nx >= BF) begin
							sum_q     <= '0;
							cnt_q     <= '0;
							blk_sum_q <= sum_nx;
							state_q   <= ST_AVG;
						end else begin
							sum_q   <= sum_nx;
							cnt_q   <= cnt_nx[3:0];
							state_q <= ST_TGT;
						end
					end
				end
				ST_AVG: begin
					avg_q   <= avg_prod[AVG_SH+11:AVG_SH];
					state_q <= ST_TGT;
				end
				ST_TGT: begin
					blank_q <= level_q < sensitivity;
					if (level_q < sensitivity) begin
						target_q <= '0;
						state_q  <= ST_EMIT;
					end else if (level_q < avg_q) begin
						below_q            <= 1'b1;
						div_req_q.start    <= 1'b1;
						div_req_q.dividend <= {1'b0, avg_q - level_q, 3'd0};
						div_req_q.divisor  <= avg_q;
						state_q            <= ST_DIV;
					end else if (avg_q == '0) begin
						target_q <= MB;
						state_q  <= ST_EMIT;
					end else begin
						below_q            <= 1'b0;
						div_req_q.start    <= 1'b1;
						div_req_q.dividend <= {1'b0, level_q - avg_q, 3'd0};
						div_req_q.divisor  <= avg_q;
						state_q            <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						target_q <= tgt_div;
						state_q  <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (ld) begin
						res_q.hue <= hue_q;
						if (blank_q) begin
							res_valid_q       <= 1'b1;
							res_q.frame_kind  <= KIND_BLANK;
							res_q.bars_lit    <= '0;
							res_q.target_bars <= '0;
							res_q.last        <= (bars_q == target_q);
							blank_q           <= 1'b0;
						end else if (bars_q > target_q) begin
							res_valid_q       <= 1'b1;
							res_q.frame_kind  <= KIND_STEP;
							res_q.bars_lit    <= bars_q;
							res_q.target_bars <= target_q;
							res_q.last        <= (bars_q - 4'd1 == target_q);
							bars_q            <= bars_q - 4'd1;
						end else if (bars_q < target_q) begin
							res_valid_q       <= 1'b1;
							res_q.frame_kind  <= KIND_STEP;
							res_q.bars_lit    <= bars_q;
							res_q.target_bars <= target_q;
							res_q.last        <= (bars_q + 4'd1 == target_q);
							bars_q            <= bars_q + 4'd1;
						end else begin
							shown_q <= target_q;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/audio_bar_level_meter.sv]
// top level of the audio bar level meter
//
//   port group   dir  handshake             word
//   smp          in   smp_valid/smp_stall   sample, frame_end
//   res          out  res_valid/res_stall   frame_kind, bars_lit, hue, target_bars, last
//   cfg          in   cfg_we                cfg_idx, cfg_wdata
//
// a sample that does not close a frame only updates the peak
// a frame end passes the back end through a 16-step divide for the target and emits
// up to 11 words; closing a block adds an averaging step first, and a blank frame or
// a zero average skips the divide
// the two-entry level queue lets the front keep taking samples while the back works
// smp_stall rises only when the level queue is full; res_stall holds the output word
// reset clears all control state, sensitivity to 200, quiet level to 240, average to 20
module audio_bar_level_meter import abl_pkg::*; #(
	parameter int BLOCK_FRAMES = 10,
	parameter int MAX_BARS     = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        smp_valid,
	output logic        smp_stall,
	input  smp_t        smp,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [11:0] cfg_wdata
);

	logic [11:0] sens_q;
	logic [11:0] quiet_q;
	lvl_word_t   push;
	lvl_word_t   head;
	logic        lq_full;
	logic        pop;
	div_req_t    div_req;
	div_rsp_t    div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q  <= SENS_RESET;
			quiet_q <= QUIET_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_SENS:  sens_q  <= cfg_wdata;
				CFG_QUIET: quiet_q <= cfg_wdata;
				default:   sens_q  <= sens_q;
			endcase
		end
	end

	abl_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.smp_valid   (smp_valid),
		.smp_stall   (smp_stall),
		.smp         (smp),
		.quiet_level (quiet_q),
		.lq_full     (lq_full),
		.push        (push)
	);

	abl_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (lq_full),
		.pop    (pop),
		.head   (head)
	);

	abl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	abl_back #(
		.BLOCK_FRAMES (BLOCK_FRAMES),
		.MAX_BARS     (MAX_BARS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.sensitivity (sens_q),
		.head        (head),
		.pop         (pop),
		.div_req     (div_req),
		.div_rsp     (div_rsp),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res)
	);

	// a blank word never shows lit bars or a target
	a_blank_dark: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.frame_kind == KIND_BLANK) |->
			(res.bars_lit == 4'd0) && (res.target_bars == 4'd0))
		else $error("blank word carries bars");

	a_bars_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ({1'b0, res.target_bars} <= 5'(MAX_BARS)) &&
			({1'b0, res.bars_lit} <= 5'(MAX_BARS)))
		else $error("bar count beyond maximum");

	// the closing step of an animation lands one bar from the target
	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.frame_kind == KIND_STEP) && res.last |->
			({1'b0, res.bars_lit} + 5'd1 == {1'b0, res.target_bars}) ||
			({1'b0, res.bars_lit} == {1'b0, res.target_bars} + 5'd1))
		else $error("last step not adjacent to target");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.hue < HUE_WRAP))
		else $error("hue out of range");

endmodule

[tb/sv/tb_audio_bar_level_meter.sv]
// self-checking testbench for the audio bar level meter
`timescale 1ns / 1ps

module tb_audio_bar_level_meter;
	import abl_pkg::*;

	localparam int BLOCK_FRAMES = 10;
	localparam int MAX_BARS     = 10;
	localparam int PERIOD       = 8;
	localparam int SETTLE       = 128;
	localparam int LIMIT        = 400000;
	localparam int RAND_WORDS   = 80;

	typedef struct packed {
		logic        is_cfg;
		logic [11:0] val;
		logic [11:0] aux;
		logic        fe;
		logic        typed;
		res_t        want;
	} drow_t;

	localparam res_t NO_WORD = '0;
	localparam int N_ROWS = 23;

	// item rows: val is the sample; register rows: val is sensitivity, aux is quiet level
	localparam drow_t SCRIPT [N_ROWS] = '{
		'{1'b0, 12'd0,    12'd0,    1'b0, 1'b0, NO_WORD},
		// silent frame at reset settings blanks with nothing to step
		'{1'b0, 12'd240,  12'd0,    1'b1, 1'b1, '{KIND_BLANK, 4'd0, 9'd60, 4'd0, 1'b1}},
		'{1'b0, 12'd4095, 12'd0,    1'b1, 1'b0, NO_WORD},
		'{1'b0, 12'd0,    12'd0,    1'b0, 1'b0, NO_WORD},
		// blank word followed by the full fall from the top
		'{1'b0, 12'd240,  12'd0,    1'b1, 1'b0, NO_WORD},
		'{1'b1, 12'd0,    12'd4095, 1'b0, 1'b0, NO_WORD},
		// target equals shown count, no word at all
		'{1'b0, 12'd4095, 12'd0,    1'b1, 1'b0, NO_WORD},
		'{1'b0, 12'd0,    12'd0,    1'b1, 1'b0, NO_WORD},
		'{1'b0, 12'd4095, 12'd0,    1'b1, 1'b0, NO_WORD},
		// below the average, then exactly on it
		'{1'b0, 12'd4085, 12'd0,    1'b1, 1'b0, NO_WORD},
		'{1'b0, 12'd4075, 12'd0,    1'b1, 1'b0, NO_WORD},
		'{1'b0, 12'd4095, 12'd0,    1'b1, 1'b0, NO_WORD},
		'{1'b0, 12'd4095, 12'd0,    1'b1, 1'b0, NO_WORD},
		// a silent block drives the average to zero
		'{1'b0, 12'd4095, 12'd0,    1'b1, 1'b0, NO_WORD},
		'{1'b0, 12'd4095, 12'd0,    1'b1, 1'b0, NO_WORD},
		'{1'b0, 12'd4095, 12'd0,    1'b1, 1'b0, NO_WORD},
		'{1'b0, 12'd4095, 12'd0,    1'b1, 1'b0, NO_WORD},
		'{1'b0, 12'd4095, 12'd0,    1'b1, 1'b0, NO_WORD},
		'{1'b0, 12'd4095, 12'd0,    1'b1, 1'b0, NO_WORD},
		'{1'b0, 12'd4095, 12'd0,    1'b1, 1'b0, NO_WORD},
		'{1'b0, 12'd4095, 12'd0,    1'b1, 1'b0, NO_WORD},
		'{1'b0, 12'd4095, 12'd0,    1'b1, 1'b0, NO_WORD},
		// zero average at the level saturates to full scale
		'{1'b0, 12'd4095, 12'd0,    1'b1, 1'b0, NO_WORD}
	};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        smp_valid = 1'b0;
	logic        smp_stall;
	smp_t        smp       = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	res_t        res;
	logic        cfg_we    = 1'b0;
	logic        cfg_idx   = CFG_SENS;
	logic [11:0] cfg_wdata = '0;

	// predictor state
	logic [11:0] meter_sens        = SENS_RESET;
	logic [11:0] meter_quiet       = QUIET_RESET;
	logic [11:0] peak_now          = '0;
	logic [15:0] level_acc         = '0;
	int          block_frames_seen = 0;
	logic [11:0] level_avg         = AVG_RESET;
	int          bars_shown        = 0;
	logic [8:0]  hue_deg           = '0;

	res_t bar_steps_due [$];
	int   mismatches = 0;
	int   cycles     = 0;
	int   snd_idle   = 0;
	int   rcv_idle   = 0;

	audio_bar_level_meter #(
		.BLOCK_FRAMES(BLOCK_FRAMES),
		.MAX_BARS    (MAX_BARS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.smp_valid(smp_valid),
		.smp_stall(smp_stall),
		.smp      (smp),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always #(PERIOD / 2) clk = ~clk;

	function automatic res_t bar_word(input logic kind, input int bars, input int tgt,
			input logic fin);
		res_t r;
		r.frame_kind  = kind;
		r.bars_lit    = bars[3:0];
		r.hue         = hue_deg;
		r.target_bars = tgt[3:0];
		r.last        = fin;
		return r;
	endfunction

	task automatic compute_bar_steps(input smp_t w, input logic emit);
		int   lv;
		int   av;
		int   c;
		int   tgt;
		int   b;
		logic blank;
		if (w.sample > peak_now)
			peak_now = w.sample;
		if (!w.frame_end)
			return;
		lv = int'((peak_now >= meter_quiet) ? peak_now - meter_quiet
		                                    : meter_quiet - peak_now);
		peak_now = '0;
		level_acc = level_acc + lv[15:0];
		if (block_frames_seen + 1 >= BLOCK_FRAMES) begin
			level_avg = 12'(level_acc / BLOCK_FRAMES);
			level_acc = '0;
			block_frames_seen = 0;
		end else begin
			block_frames_seen++;
		end
		av = int'(level_avg);
		blank = lv < meter_sens;
		if (blank) begin
			tgt = 0;
		end else if (lv < av) begin
			// ceil of the scaled shortfall
			c = (8 * (av - lv) + av - 1) / av;
			tgt = (c >= 7) ? 0 : 7 - c;
		end else if (av == 0) begin
			tgt = MAX_BARS;
		end else begin
			tgt = 8 * (lv - av) / av + 8;
		end
		if (tgt > MAX_BARS)
			tgt = MAX_BARS;
		hue_deg = hue_deg + HUE_STEP;
		if (hue_deg >= HUE_WRAP)
			hue_deg = '0;
		b = bars_shown;
		bars_shown = tgt;
		if (!emit)
			return;
		if (blank)
			bar_steps_due.push_back(bar_word(KIND_BLANK, 0, 0, b == tgt));
		while (b > tgt) begin
			bar_steps_due.push_back(bar_word(KIND_STEP, b, tgt, b - 1 == tgt));
			b--;
		end
		while (b < tgt) begin
			bar_steps_due.push_back(bar_word(KIND_STEP, b, tgt, b + 1 == tgt));
			b++;
		end
	endtask

	task automatic send_word(input smp_t w, input logic typed, input res_t want);
		while ($urandom_range(0, 99) < snd_idle) begin
			smp_valid <= 1'b0;
			@(posedge clk);
		end
		smp_valid <= 1'b1;
		smp       <= w;
		@(posedge clk);
		while (smp_stall)
			@(posedge clk);
		compute_bar_steps(w, !typed);
		if (typed)
			bar_steps_due.push_back(want);
	endtask

	// drain everything, let a silent frame end finish, then load both registers
	task automatic write_regs(input logic [11:0] sens, input logic [11:0] quiet);
		smp_valid <= 1'b0;
		@(posedge clk);
		while (bar_steps_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= CFG_SENS;
		cfg_wdata <= sens;
		@(posedge clk);
		cfg_idx   <= CFG_QUIET;
		cfg_wdata <= quiet;
		@(posedge clk);
		cfg_we    <= 1'b0;
		meter_sens  = sens;
		meter_quiet = quiet;
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (bar_steps_due.size() == 0) begin
					$display("%0t: word with none due, act kind %0d bars %0d hue %0d tgt %0d last %0d",
						$time, res.frame_kind, res.bars_lit, res.hue, res.target_bars, res.last);
					mismatches++;
				end else begin
					want = bar_steps_due.pop_front();
					if (res.frame_kind !== want.frame_kind || res.bars_lit !== want.bars_lit ||
							res.hue !== want.hue || res.target_bars !== want.target_bars ||
							res.last !== want.last) begin
						$display("%0t: exp kind %0d bars %0d hue %0d tgt %0d last %0d", $time,
							want.frame_kind, want.bars_lit, want.hue, want.target_bars, want.last);
						$display("%0t: act kind %0d bars %0d hue %0d tgt %0d last %0d", $time,
							res.frame_kind, res.bars_lit, res.hue, res.target_bars, res.last);
						mismatches++;
					end
				end
			end
			res_stall <= ($urandom_range(0, 99) < rcv_idle);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("audio_bar_level_meter verification failed");
			$finish;
		end
	end

	initial begin
		smp_t w;
		int   k;
		int   phase;
		int   sent;
		int   len;
		int   spread;
		int   s;
		int   pick;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		snd_idle = 6;
		rcv_idle = 79;
		for (k = 0; k < N_ROWS; k++) begin
			if (SCRIPT[k].is_cfg) begin
				write_regs(SCRIPT[k].val, SCRIPT[k].aux);
			end else begin
				w.sample    = SCRIPT[k].val;
				w.frame_end = SCRIPT[k].fe;
				send_word(w, SCRIPT[k].typed, SCRIPT[k].want);
			end
		end
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					write_regs(12'd4095, 12'd0);
				end
				1: begin
					snd_idle = 79;
					rcv_idle = 6;
					write_regs(12'($urandom_range(0, 300)), 12'($urandom_range(1500, 2600)));
				end
				default: begin
					snd_idle = 0;
					rcv_idle = 0;
					write_regs(12'($urandom_range(0, 150)), 12'($urandom_range(0, 4095)));
				end
			endcase
			sent = 0;
			while (sent < RAND_WORDS) begin
				len    = $urandom_range(1, 8);
				spread = $urandom_range(0, 2000);
				for (int j = 0; j < len; j++) begin
					pick = $urandom_range(0, 19);
					if (pick == 0) begin
						s = 4095;
					end else if (pick == 1) begin
						s = 0;
					end else if (pick < 4) begin
						s = $urandom_range(0, 4095);
					end else begin
						s = int'(meter_quiet);
						s = s - spread + int'($urandom_range(0, 2 * spread));
						if (s < 0)
							s = 0;
						if (s > 4095)
							s = 4095;
					end
					w.sample    = s[11:0];
					w.frame_end = (j == len - 1);
					send_word(w, 1'b0, NO_WORD);
					sent++;
					// hold off mid-phase until every due word has come out
					if (phase == 1 && sent == RAND_WORDS / 2) begin
						smp_valid <= 1'b0;
						@(posedge clk);
						while (bar_steps_due.size() != 0)
							@(posedge clk);
					end
				end
			end
		end
		smp_valid <= 1'b0;
		@(posedge clk);
		while (bar_steps_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("audio_bar_level_meter verification clean");
		else
			$display("audio_bar_level_meter verification failed");
		$finish;
	end

endmodule

[audio_bar_level_meter.f]
rtl/abl_pkg.sv
rtl/abl_front.sv
rtl/abl_fifo.sv
rtl/abl_div.sv
rtl/abl_back.sv
rtl/audio_bar_level_meter.sv
tb/sv/tb_audio_bar_level_meter.sv
